// ----- rtl/ppm_pkg.sv -----
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types and codes for the ASCII PPM stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ppm_pkg;

   localparam int unsigned MaxDimDefault = 4096;
   localparam int unsigned RspDepth      = 4;

   // result kinds
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;
   localparam logic [1:0] KIND_EOF    = 2'd3;

   // error codes
   localparam logic [2:0] ERR_MAGIC     = 3'd0;
   localparam logic [2:0] ERR_SEPARATOR = 3'd1;
   localparam logic [2:0] ERR_OVER_MAX  = 3'd2;
   localparam logic [2:0] ERR_DIMENSION = 3'd3;
   localparam logic [2:0] ERR_SURPLUS   = 3'd4;
   localparam logic [2:0] ERR_TRUNCATED = 3'd5;

   // parse phases
   localparam logic [2:0] PH_MAGIC  = 3'd0;
   localparam logic [2:0] PH_WIDTH  = 3'd1;
   localparam logic [2:0] PH_HEIGHT = 3'd2;
   localparam logic [2:0] PH_MAX    = 3'd3;
   localparam logic [2:0] PH_PIXELS = 3'd4;
   localparam logic [2:0] PH_STOP   = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [11:0] pixel_column;
      logic [11:0] pixel_row;
      logic [7:0]  red_value;
      logic [7:0]  green_value;
      logic [7:0]  blue_value;
      logic [12:0] out_width;
      logic [12:0] out_height;
      logic [7:0]  out_max_value;
      logic [2:0]  error_code;
      logic        result_last;
   } rsp_item_type;

   // results of one byte, handed to the output queue
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type slot0;
      rsp_item_type slot1;
   } rsp_push_type;

endpackage

`default_nettype wire

// ----- rtl/ppm_ascii_stream_parser_core.sv -----
// ----------------------------------------------------------------------------
// ppm_ascii_stream_parser_core
// ASCII PPM byte-stream parser: header, pixel triples, errors, end of file.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake             payload
//   req_      in   req_valid/req_stall   req_item_type (data_byte, is_last)
//   rsp_      out  rsp_valid/rsp_stall   rsp_item_type (kind, pixel, header, error)
//
// One byte is accepted per cycle unless req_stall is high; a byte's first result
// passes the input register, then the result queue, before it is offered.
// A byte causing two results (pixel or header plus end of file) writes both
// into the four-entry result queue together, which hands them out one at a time.
// The input stalls only when the queue has fewer than two free entries.
// Synchronous reset clears the parser state and the queue; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_ascii_stream_parser_core import ppm_pkg::*; #(
   parameter int unsigned MAX_DIM = MaxDimDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         room;
   logic         fire;
   logic         accept;
   rsp_push_type push;

   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept)    in_valid_in = 1'b1;
      else if (fire) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) in_item_ff <= req_item;
   end

   ppm_parser #(
      .MAX_DIM (MAX_DIM)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req_item (in_item_ff),
      .push     (push)
   );

   ppm_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ----- rtl/ppm_parser.sv -----
// ----------------------------------------------------------------------------
// ppm_parser
// Parser state and the single-pass next-state and result logic for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_parser import ppm_pkg::*; #(
   parameter int unsigned MAX_DIM = MaxDimDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire req_item_type req_item,
   output rsp_push_type      push
);

   localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
   localparam int unsigned COL_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam logic [16:0] MaxDimVal = 17'(MAX_DIM);

   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_UP_P = 8'h50;
   localparam logic [7:0] CH_LO_P = 8'h70;
   localparam logic [7:0] CH_ONE  = 8'h31;
   localparam logic [7:0] CH_SIX  = 8'h36;

   logic [2:0]       phase_ff,     phase_in;
   logic             comment_ff,   comment_in;
   logic             saw_letter_ff, saw_letter_in;
   logic [15:0]      number_ff,    number_in;
   logic             num_active_ff, num_active_in;
   logic             need_sep_ff,  need_sep_in;
   logic [DIM_W-1:0] width_ff,     width_in;
   logic [DIM_W-1:0] height_ff,    height_in;
   logic [7:0]       max_color_ff, max_color_in;
   logic [1:0]       comp_ff,      comp_in;
   logic [7:0]       red_ff,       red_in;
   logic [7:0]       green_ff,     green_in;
   logic [COL_W-1:0] column_ff,    column_in;
   logic [DIM_W-1:0] row_ff,       row_in;

   logic [7:0]       b;
   logic [19:0]      acc_wide;
   logic [15:0]      acc_val;
   logic             close_go;
   logic             close_end;
   logic [15:0]      close_val;
   logic             term_ok;
   logic [DIM_W-1:0] col_next;
   logic [1:0]       res_n;
   rsp_item_type     slot_v [2];

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic rsp_item_type make_error(input logic [2:0] code);
      rsp_item_type r;
      r = '0;
      r.result_kind = KIND_ERROR;
      r.error_code  = code;
      return r;
   endfunction

   assign b        = req_item.data_byte;
   // value * 10 + digit, saturating at 16 bits
   assign acc_wide = {1'b0, number_ff, 3'b000} + {3'b000, number_ff, 1'b0} + {16'h0000, b[3:0]};
   assign acc_val  = (|acc_wide[19:16]) ? 16'hFFFF : acc_wide[15:0];
   assign col_next = DIM_W'(column_ff) + DIM_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      comment_in    = comment_ff;
      saw_letter_in = saw_letter_ff;
      number_in     = number_ff;
      num_active_in = num_active_ff;
      need_sep_in   = need_sep_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      max_color_in  = max_color_ff;
      comp_in       = comp_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      close_go      = 1'b0;
      close_end     = 1'b0;
      close_val     = '0;
      term_ok       = 1'b0;
      res_n         = 2'd0;
      slot_v[0]     = '0;
      slot_v[1]     = '0;

      if (phase_ff < PH_STOP) begin
         // byte itself
         priority if (comment_ff) begin
            if (b == CH_LF) comment_in = 1'b0;
         end else if (phase_ff == PH_MAGIC) begin
            priority if (saw_letter_ff) begin
               saw_letter_in = 1'b0;
               if (b >= CH_ONE && b <= CH_SIX) begin
                  need_sep_in = 1'b1;
                  phase_in    = PH_WIDTH;
               end else begin
                  slot_v[res_n[0]] = make_error(ERR_MAGIC);
                  res_n    = res_n + 2'd1;
                  phase_in = PH_STOP;
               end
            end else if (b == CH_UP_P || b == CH_LO_P) begin
               saw_letter_in = 1'b1;
            end else if (b == CH_HASH) begin
               comment_in = 1'b1;
            end else if (!(is_ws(b) && b != CH_LF)) begin
               slot_v[res_n[0]] = make_error(ERR_MAGIC);
               res_n    = res_n + 2'd1;
               phase_in = PH_STOP;
            end else begin
               // blanks before the magic are skipped
            end
         end else if (phase_ff != PH_PIXELS) begin
            priority if (need_sep_ff) begin
               need_sep_in = 1'b0;
               if (b == CH_HASH) begin
                  comment_in = 1'b1;
               end else if (!is_ws(b)) begin
                  slot_v[res_n[0]] = make_error(ERR_SEPARATOR);
                  res_n    = res_n + 2'd1;
                  phase_in = PH_STOP;
               end
            end else if (is_dig(b)) begin
               number_in     = acc_val;
               num_active_in = 1'b1;
            end else if (num_active_ff) begin
               close_go = 1'b1;
            end else if (b == CH_HASH) begin
               comment_in = 1'b1;
            end else if (!is_ws(b)) begin
               slot_v[res_n[0]] = make_error(ERR_SEPARATOR);
               res_n    = res_n + 2'd1;
               phase_in = PH_STOP;
            end else begin
               // blanks before a field are skipped
            end
         end else begin
            if (is_dig(b)) begin
               number_in     = acc_val;
               num_active_in = 1'b1;
            end else if (num_active_ff) begin
               close_go = 1'b1;
            end
         end

         // a number still open at the last byte closes without a terminator
         if (req_item.is_last && !close_go && phase_in < PH_STOP && num_active_in
             && phase_in != PH_MAGIC) begin
            close_go  = 1'b1;
            close_end = 1'b1;
         end

         close_val = number_in;
         if (close_go) begin
            number_in     = '0;
            num_active_in = 1'b0;
            if (phase_in != PH_PIXELS) begin
               if (phase_in == PH_MAX) term_ok = (b == CH_LF) || (b == CH_HASH);
               else                    term_ok = is_ws(b) || (b == CH_HASH);
               priority if (!close_end && !term_ok) begin
                  slot_v[res_n[0]] = make_error(ERR_SEPARATOR);
                  res_n    = res_n + 2'd1;
                  phase_in = PH_STOP;
               end else if (phase_in != PH_MAX) begin
                  if (close_val == 16'd0 || {1'b0, close_val} > MaxDimVal) begin
                     slot_v[res_n[0]] = make_error(ERR_DIMENSION);
                     res_n    = res_n + 2'd1;
                     phase_in = PH_STOP;
                  end else begin
                     if (phase_in == PH_WIDTH) begin
                        width_in = DIM_W'(close_val);
                        phase_in = PH_HEIGHT;
                     end else begin
                        height_in = DIM_W'(close_val);
                        phase_in  = PH_MAX;
                     end
                     if (!close_end && b == CH_HASH) comment_in = 1'b1;
                  end
               end else begin
                  if (close_val == 16'd0 || close_val > 16'd255) begin
                     slot_v[res_n[0]] = make_error(ERR_DIMENSION);
                     res_n    = res_n + 2'd1;
                     phase_in = PH_STOP;
                  end else begin
                     max_color_in = close_val[7:0];
                     phase_in     = PH_PIXELS;
                     slot_v[res_n[0]]               = '0;
                     slot_v[res_n[0]].result_kind   = KIND_HEADER;
                     slot_v[res_n[0]].out_width     = 13'(width_in);
                     slot_v[res_n[0]].out_height    = 13'(height_in);
                     slot_v[res_n[0]].out_max_value = close_val[7:0];
                     res_n = res_n + 2'd1;
                     if (!close_end && b == CH_HASH) comment_in = 1'b1;
                  end
               end
            end else begin
               priority if (close_val > {8'h00, max_color_ff}) begin
                  slot_v[res_n[0]] = make_error(ERR_OVER_MAX);
                  res_n    = res_n + 2'd1;
                  phase_in = PH_STOP;
               end else if (comp_ff != 2'd2) begin
                  if (comp_ff == 2'd0) begin
                     red_in  = close_val[7:0];
                     comp_in = 2'd1;
                  end else begin
                     green_in = close_val[7:0];
                     comp_in  = 2'd2;
                  end
                  // red and green must end on whitespace
                  if (!close_end && !is_ws(b)) begin
                     slot_v[res_n[0]] = make_error(ERR_SEPARATOR);
                     res_n    = res_n + 2'd1;
                     phase_in = PH_STOP;
                  end
               end else begin
                  comp_in = 2'd0;
                  if (row_ff >= height_ff) begin
                     slot_v[res_n[0]] = make_error(ERR_SURPLUS);
                     res_n    = res_n + 2'd1;
                     phase_in = PH_STOP;
                  end else begin
                     slot_v[res_n[0]]              = '0;
                     slot_v[res_n[0]].result_kind  = KIND_PIXEL;
                     slot_v[res_n[0]].pixel_column = 12'(column_ff);
                     slot_v[res_n[0]].pixel_row    = 12'(height_ff - row_ff - DIM_W'(1));
                     slot_v[res_n[0]].red_value    = red_ff;
                     slot_v[res_n[0]].green_value  = green_ff;
                     slot_v[res_n[0]].blue_value   = close_val[7:0];
                     res_n = res_n + 2'd1;
                     if (col_next >= width_ff) begin
                        column_in = '0;
                        row_in    = row_ff + DIM_W'(1);
                     end else begin
                        column_in = COL_W'(col_next);
                     end
                  end
               end
            end
         end

         // end of file
         if (req_item.is_last && phase_in < PH_STOP) begin
            if (phase_in == PH_PIXELS) begin
               slot_v[res_n[0]]             = '0;
               slot_v[res_n[0]].result_kind = KIND_EOF;
               res_n = res_n + 2'd1;
            end else begin
               slot_v[res_n[0]] = make_error(ERR_TRUNCATED);
               res_n = res_n + 2'd1;
            end
            phase_in = PH_STOP;
         end
      end

      if (res_n == 2'd1) slot_v[0].result_last = 1'b1;
      if (res_n == 2'd2) slot_v[1].result_last = 1'b1;
   end

   assign push.count = fire ? res_n : 2'd0;
   assign push.slot0 = slot_v[0];
   assign push.slot1 = slot_v[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC;
         comment_ff    <= 1'b0;
         saw_letter_ff <= 1'b0;
         number_ff     <= '0;
         num_active_ff <= 1'b0;
         need_sep_ff   <= 1'b0;
         width_ff      <= '0;
         height_ff     <= '0;
         max_color_ff  <= '0;
         comp_ff       <= '0;
         red_ff        <= '0;
         green_ff      <= '0;
         column_ff     <= '0;
         row_ff        <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         comment_ff    <= comment_in;
         saw_letter_ff <= saw_letter_in;
         number_ff     <= number_in;
         num_active_ff <= num_active_in;
         need_sep_ff   <= need_sep_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         max_color_ff  <= max_color_in;
         comp_ff       <= comp_in;
         red_ff        <= red_in;
         green_ff      <= green_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
      end
   end

   a_stopped_quiet: assert property (@(posedge clock) disable iff (reset)
      (fire && phase_ff >= PH_STOP) |-> push.count == 2'd0)
      else $error("result produced after parsing stopped");

   a_at_most_two: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("more than two results for one byte");

   a_header_phase: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0 && push.slot0.result_kind == KIND_HEADER)
      |=> (phase_ff == PH_PIXELS || phase_ff == PH_STOP))
      else $error("header result without entering the pixel section");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= height_ff || phase_ff < PH_PIXELS)
      else $error("row count passed the image height");

endmodule

`default_nettype wire

// ----- rtl/ppm_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// ppm_rsp_queue
// Small result queue: takes up to two items a cycle, delivers one unless rsp_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_rsp_queue import ppm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire rsp_push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item
);

   localparam int unsigned PTR_W = $clog2(RspDepth);
   localparam int unsigned CNT_W = $clog2(RspDepth + 1);

   rsp_item_type     entry_ff [RspDepth];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic             pop;

   assign pop         = rsp_valid && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);
   assign room        = count_ff <= CNT_W'(RspDepth - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_item    = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff]   <= push.slot0;
      if (push.count == 2'd2) entry_ff[wr_ptr_next] <= push.slot1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RspDepth))
      else $error("result queue overfilled");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("push without room for two items");

   a_pair_count: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2 && !pop) |=> count_ff == $past(count_ff) + CNT_W'(2))
      else $error("paired push lost an item");

endmodule

`default_nettype wire
